// ----- rtl/wfgs_pkg.sv -----
package wfgs_pkg;

    localparam int GENO_ENTRIES  = 64;
    localparam int MAX_NEIGHBORS = 16;
    localparam int COUNT_BITS    = 16;
    localparam int GI_BITS       = 6;
    localparam int NS_BITS       = 4;
    localparam int NT_BITS       = 5;
    localparam int WT_BITS       = 48;
    localparam int ACC_BITS      = 56;
    localparam int TGT_BITS      = 88;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_NEIGH   = 3'd1;
    localparam logic [2:0] OP_DRAW    = 3'd2;
    localparam logic [2:0] OP_ADVANCE = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic [1:0] CFG_POP  = 2'd0;
    localparam logic [1:0] CFG_MUT  = 2'd1;
    localparam logic [1:0] CFG_SCAN = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NONB  = 2'd2;

    // Control from the sequencer to every cell
    typedef struct packed {
        logic                  shift;    // rotate ring by one
        logic                  load;     // write head cell
        logic [COUNT_BITS-1:0] load_cnt;
        logic [31:0]           load_fit;
        logic                  neigh;    // write neighbor count in head
        logic [NT_BITS-1:0]    neigh_tot;
        logic                  inc;      // increment next count of head
        logic                  advance;  // next -> current, clear next
    } cell_ctl_t;

    // Data one cell hands to its neighbor
    typedef struct packed {
        logic [COUNT_BITS-1:0] cur;
        logic [COUNT_BITS-1:0] nxt;
        logic [31:0]           fit;
        logic [NT_BITS-1:0]    ncnt;
    } cell_data_t;

endpackage

// ----- rtl/wfgs_cell.sv -----
module wfgs_cell
    import wfgs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       is_head,
    input  cell_ctl_t  ctl,
    input  cell_data_t prev,
    output cell_data_t data
);

    cell_data_t d_reg, d_next;

    always_comb begin
        d_next = d_reg;
        if (ctl.advance) begin
            d_next.cur = d_reg.nxt;
            d_next.nxt = '0;
        end else if (ctl.shift) begin
            d_next = prev;
        end else if (is_head) begin
            if (ctl.load) begin
                d_next.cur = ctl.load_cnt;
                d_next.fit = ctl.load_fit;
            end
            if (ctl.neigh) begin
                d_next.ncnt = ctl.neigh_tot;
            end
            if (ctl.inc && d_reg.nxt != COUNT_MAX) begin
                d_next.nxt = d_reg.nxt + 1'b1;
            end
        end
    end

    // Counts reset to zero; fitness is undefined until written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.cur  <= '0;
            d_reg.nxt  <= '0;
            d_reg.ncnt <= '0;
        end else begin
            d_reg.cur  <= d_next.cur;
            d_reg.nxt  <= d_next.nxt;
            d_reg.ncnt <= d_next.ncnt;
        end
        d_reg.fit <= d_next.fit;
    end

    assign data = d_reg;

endmodule

// ----- rtl/wfgs_ring.sv -----
module wfgs_ring
    import wfgs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctl_t  ctl,
    output cell_data_t head
);

    cell_data_t cd [GENO_ENTRIES];

    // Cell 0 is the head; data rotates toward lower indices
    for (genvar i = 0; i < GENO_ENTRIES; i++) begin : g_cell
        wfgs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .is_head (i == 0),
            .ctl     (ctl),
            .prev    (cd[(i + 1) % GENO_ENTRIES]),
            .data    (cd[i])
        );
    end

    assign head = cd[0];

endmodule

// ----- rtl/wright_fisher_generation_sampler_top.sv -----
// Wright-Fisher generation sampler. Per-genotype counts, fitness and neighbor
// counts live in a ring of 64 cells that rotates one place per cycle while
// shifting; the neighbor list is a 1024-entry memory. Read and unused opcodes
// take one revolution plus the output step; load and neighbor load add a
// write step at the head entry, which holds the ring; advance goes straight
// to the output step. A draw takes a revolution to sum the weights, the target
// product as low and high words, a revolution to scan, the neighbor lookup,
// and a revolution plus one write to bump the next count; a draw on an empty
// population skips that last revolution.
// One result per transfer; the output register holds it until taken, and
// the next input is accepted only after that.
module wright_fisher_generation_sampler_top
    import wfgs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[2:0] genotype[8:3] count[24:9] fitness[56:25] neighbor_slot[60:57]
    // neighbor_genotype[66:61] neighbor_total[71:67] uniform_pick[103:72]
    // uniform_mutate[135:104]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // chosen_genotype[5:0] was_mutated[6] count_value[22:7] status[24:23]
    output logic [31:0]  m_tdata
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ROT  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_TGT  = 7'b0001000,
        S_SCAN = 7'b0010000,
        S_NB   = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] pop_reg, mut_reg;
    logic [6:0]  scan_reg;
    logic [15:0] draws_reg;

    logic [2:0]  op_reg;
    logic [5:0]  g_reg;
    logic [15:0] cnt_reg;
    logic [31:0] fit_reg, um_reg, up_reg;
    logic [4:0]  ntot_reg;

    logic [6:0]  pos_reg;     // steps rotated so far in this pass
    logic [1:0]  pass_reg;    // draw: 0 sum, 1 scan, 2 return home
    logic [ACC_BITS-1:0] tf_reg, cum_reg;
    logic [23:0] ct_reg;
    logic        pop_any_reg, found_reg, usefit_reg;
    logic [5:0]  k_reg;
    logic [4:0]  kn_reg;
    logic [TGT_BITS-1:0] tgt_reg;
    logic        tgt_ph_reg;
    logic [31:0] res_reg;
    logic        mv_reg;

    logic [5:0]  nb_mem [GENO_ENTRIES*MAX_NEIGHBORS];
    logic [5:0]  nb_rd_reg;

    cell_ctl_t  ctl;
    cell_data_t head;

    wfgs_ring u_ring (.aclk(aclk), .aresetn(aresetn), .ctl(ctl), .head(head));

    logic [6:0] scan_eff;
    assign scan_eff = (scan_reg > 7'(GENO_ENTRIES)) ? 7'(GENO_ENTRIES) : scan_reg;

    logic [WT_BITS-1:0] head_wt;
    assign head_wt = 48'(head.fit) * 48'(head.cur);

    logic in_scan;
    assign in_scan = pos_reg < scan_eff;

    logic [ACC_BITS-1:0] cum_add;
    assign cum_add = cum_reg + (usefit_reg ? ACC_BITS'(head_wt) : ACC_BITS'(head.cur));

    // Target product in two 32x32 steps: low word, then high word shifted up
    logic [ACC_BITS-1:0] tgt_base;
    assign tgt_base = (tf_reg != '0) ? tf_reg : ACC_BITS'(ct_reg);
    logic [31:0] tgt_part;
    assign tgt_part = tgt_ph_reg ? 32'(tgt_base[ACC_BITS-1:32]) : tgt_base[31:0];
    logic [63:0] tgt_prod;
    assign tgt_prod = 64'(tgt_part) * 64'(up_reg);

    assign s_tready  = (state_reg == S_IDLE) && !mv_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = res_reg;

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // Sequencer control into the ring
    always_comb begin
        ctl = '0;
        ctl.load_cnt  = cnt_reg;
        ctl.load_fit  = fit_reg;
        ctl.neigh_tot = (ntot_reg > 5'(MAX_NEIGHBORS)) ? 5'(MAX_NEIGHBORS) : ntot_reg;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_acc) begin
                state_next = S_ROT;
                if (s_tdata[2:0] == OP_DRAW) state_next = S_SUM;
                if (s_tdata[2:0] == OP_ADVANCE) state_next = S_OUT;
            end
            S_ROT: begin
                if (pos_reg == 7'({1'b0, g_reg})) begin
                    ctl.load  = (op_reg == OP_LOAD);
                    ctl.neigh = (op_reg == OP_NEIGH);
                end
                if (pos_reg == 7'(GENO_ENTRIES)) state_next = S_OUT;
                else ctl.shift = !(pos_reg == 7'({1'b0, g_reg}) &&
                                  (op_reg == OP_LOAD || op_reg == OP_NEIGH) &&
                                  !tgt_ph_reg);
            end
            S_SUM: begin
                if (pos_reg == 7'(GENO_ENTRIES)) state_next = S_TGT;
                else ctl.shift = 1'b1;
            end
            S_TGT: if (tgt_ph_reg) state_next = S_SCAN;
            S_SCAN: begin
                if (pass_reg == 2'd1 && pos_reg == 7'(GENO_ENTRIES))
                    state_next = S_NB;
                else if (pass_reg == 2'd2 && pos_reg == 7'(GENO_ENTRIES))
                    state_next = S_OUT;
                else if (pass_reg == 2'd2 && pos_reg == 7'({1'b0, k_reg}) && !tgt_ph_reg)
                    ctl.inc = 1'b1;
                else ctl.shift = 1'b1;
            end
            // an empty population changes no count, so skip the return pass
            S_NB: if (tgt_ph_reg) state_next = pop_any_reg ? S_SCAN : S_OUT;
            S_OUT: begin
                ctl.advance = (op_reg == OP_ADVANCE) && !tgt_ph_reg;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic draw_mut;
    assign draw_mut = draws_reg < mut_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pop_reg   <= 16'd1;
            mut_reg   <= '0;
            scan_reg  <= 7'd64;
            draws_reg <= '0;
            mv_reg    <= 1'b0;
            tgt_ph_reg <= 1'b0;
            pos_reg   <= '0;
            pass_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_POP:  pop_reg  <= cfg_data;
                    CFG_MUT:  mut_reg  <= cfg_data;
                    CFG_SCAN: scan_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (mv_reg && m_tready) mv_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    pos_reg <= '0; pass_reg <= '0; tgt_ph_reg <= 1'b0;
                end
                S_ROT: begin
                    // a write holds the ring at the head entry while the head is written
                    if (pos_reg == 7'({1'b0, g_reg}) &&
                        (op_reg == OP_LOAD || op_reg == OP_NEIGH) && !tgt_ph_reg)
                        tgt_ph_reg <= 1'b1;
                    else if (pos_reg != 7'(GENO_ENTRIES)) pos_reg <= pos_reg + 1'b1;
                end
                S_SUM: if (pos_reg == 7'(GENO_ENTRIES)) pos_reg <= '0;
                       else pos_reg <= pos_reg + 1'b1;
                S_TGT: begin
                    tgt_ph_reg <= !tgt_ph_reg;
                    if (tgt_ph_reg) pass_reg <= 2'd1;
                end
                S_SCAN: begin
                    if (pos_reg == 7'(GENO_ENTRIES)) begin
                        pos_reg <= '0;
                        tgt_ph_reg <= 1'b0;
                    end else if (pass_reg == 2'd2 && pos_reg == 7'({1'b0, k_reg})
                                 && !tgt_ph_reg) begin
                        tgt_ph_reg <= 1'b1;
                    end else pos_reg <= pos_reg + 1'b1;
                end
                S_NB: begin
                    if (tgt_ph_reg) begin
                        pass_reg <= 2'd2;
                        tgt_ph_reg <= 1'b0;
                    end else begin
                        tgt_ph_reg <= 1'b1;
                    end
                end
                S_OUT: begin
                    mv_reg <= 1'b1;
                    if (op_reg == OP_ADVANCE) draws_reg <= '0;
                    if (op_reg == OP_DRAW && pop_any_reg && draws_reg != 16'hFFFF)
                        draws_reg <= draws_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath
    logic [TGT_BITS-1:0] cum_sh;
    assign cum_sh = {cum_add, 32'd0};
    logic [4:0] nidx;
    assign nidx = 5'((64'(um_reg) * 64'(kn_reg)) >> 32);

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: if (s_acc) begin
                op_reg   <= s_tdata[2:0];
                g_reg    <= s_tdata[8:3];
                cnt_reg  <= s_tdata[24:9];
                fit_reg  <= s_tdata[56:25];
                ntot_reg <= s_tdata[71:67];
                up_reg   <= s_tdata[103:72];
                um_reg   <= s_tdata[135:104];
                tf_reg <= '0; ct_reg <= '0; cum_reg <= '0;
                pop_any_reg <= 1'b0; found_reg <= 1'b0;
                if (s_tdata[2:0] == OP_NEIGH)
                    nb_mem[{s_tdata[8:3], s_tdata[60:57]}] <= s_tdata[66:61];
            end
            S_ROT: if (pos_reg == 7'({1'b0, g_reg})) cnt_reg <= head.cur;
            S_SUM: if (pos_reg != 7'(GENO_ENTRIES) && in_scan && head.cur != '0) begin
                pop_any_reg <= 1'b1;
                k_reg  <= pos_reg[5:0];
                tf_reg <= tf_reg + ACC_BITS'(head_wt);
                ct_reg <= ct_reg + 24'(head.cur);
            end
            S_TGT: begin
                usefit_reg <= (tf_reg != '0);
                if (!tgt_ph_reg) tgt_reg <= TGT_BITS'(tgt_prod);
                else tgt_reg <= tgt_reg + (TGT_BITS'(tgt_prod) << 32);
            end
            S_SCAN: if (pass_reg == 2'd1 && pos_reg != 7'(GENO_ENTRIES) && in_scan
                        && head.cur != '0 && !found_reg) begin
                cum_reg <= cum_add;
                if (cum_sh >= tgt_reg) begin
                    found_reg <= 1'b1;
                    k_reg <= pos_reg[5:0];
                    kn_reg <= head.ncnt;
                end
            end
            else if (pass_reg == 2'd1 && pos_reg == 7'(GENO_ENTRIES) && !found_reg) begin
                kn_reg <= '0;
            end
            default: ;
        endcase
        if (state_reg == S_SUM && pos_reg == 7'(GENO_ENTRIES)) kn_reg <= '0;
        if (state_reg == S_NB && !tgt_ph_reg)
            nb_rd_reg <= nb_mem[{k_reg, nidx[3:0]}];
        if (state_reg == S_NB && tgt_ph_reg && draw_mut && kn_reg != '0)
            k_reg <= nb_rd_reg;
        if (state_reg == S_OUT) begin
            case (op_reg)
                OP_DRAW: begin
                    if (!pop_any_reg) res_reg <= {7'd0, ST_EMPTY, 16'd0, 1'b0, 6'd0};
                    else res_reg <= {7'd0, (draw_mut && kn_reg == '0) ? ST_NONB : ST_OK,
                                     16'd0, draw_mut && kn_reg != '0, k_reg};
                end
                OP_READ: res_reg <= {9'd0, cnt_reg, 7'd0};
                default: res_reg <= '0;
            endcase
        end
    end

endmodule
